// ===== sv/cdte_pkg.sv =====
// ----------------------------------------------------------------------------
// cdte_pkg
// Shared constants, status codes and calendar tables for the civil date and
// time to epoch seconds converter.
// ----------------------------------------------------------------------------
package cdte_pkg;

  localparam int unsigned YEAR_W   = 14;
  localparam int unsigned FIELD_W  = 7;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned EPOCH_W  = 31;
  localparam int unsigned DAYS_W   = 15;
  localparam int unsigned YOFF_W   = 7;
  localparam int unsigned TOD_W    = 17;

  localparam logic [YEAR_W-1:0]  YEAR_MIN      = 14'd1970;
  localparam logic [YEAR_W-1:0]  YEAR_MAX      = 14'd2037;
  localparam logic [16:0]        SECS_PER_DAY  = 17'd86400;
  localparam logic [11:0]        SECS_PER_HOUR = 12'd3600;
  localparam logic [5:0]         SECS_PER_MIN  = 6'd60;
  localparam logic [8:0]         DAYS_PER_YEAR = 9'd365;
  localparam logic [EPOCH_W-1:0] EPOCH_LAST    = 31'd2145916799;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_BAD_YEAR = 2'd1,
    STATUS_BAD_DATE = 2'd2,
    STATUS_BAD_TIME = 2'd3
  } status_t;

  // days in a month, month in 1..12
  function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    case (month)
      4'd1:    len = 5'd31;
      4'd2:    len = leap ? 5'd29 : 5'd28;
      4'd3:    len = 5'd31;
      4'd4:    len = 5'd30;
      4'd5:    len = 5'd31;
      4'd6:    len = 5'd30;
      4'd7:    len = 5'd31;
      4'd8:    len = 5'd31;
      4'd9:    len = 5'd30;
      4'd10:   len = 5'd31;
      4'd11:   len = 5'd30;
      4'd12:   len = 5'd31;
      default: len = 5'd0;
    endcase
    return len;
  endfunction

  // days in the year before the first of a month
  function automatic logic [8:0] days_before_month(input logic [3:0] month,
                                                   input logic leap);
    logic [8:0] base;
    logic [8:0] extra;
    extra = (leap && (month > 4'd2)) ? 9'd1 : 9'd0;
    case (month)
      4'd1:    base = 9'd0;
      4'd2:    base = 9'd31;
      4'd3:    base = 9'd59;
      4'd4:    base = 9'd90;
      4'd5:    base = 9'd120;
      4'd6:    base = 9'd151;
      4'd7:    base = 9'd181;
      4'd8:    base = 9'd212;
      4'd9:    base = 9'd243;
      4'd10:   base = 9'd273;
      4'd11:   base = 9'd304;
      4'd12:   base = 9'd334;
      default: base = 9'd0;
    endcase
    return base + extra;
  endfunction

endpackage

// ===== sv/civil_datetime_to_epoch_seconds.sv =====
// ----------------------------------------------------------------------------
// civil_datetime_to_epoch_seconds
// Checks a calendar date and time of day and converts it to UTC seconds
// since 1970-01-01 00:00:00.
//
// Input channel: in_valid / in_stall with year, month, day, hour, minute,
// second. Output channel: out_valid / out_stall with status and
// epoch_seconds. A word moves on a rising edge with valid high, stall low.
// A word accepted at the input sits in the input register, passes the
// conversion logic, then the result register.
// Throughput is one word per cycle while the receiver does not stall; the
// result register and the input register form a two-deep pipeline, and a
// conversion is one pass through a 15 by 17 bit constant multiply and an add.
// Status 1 means a year outside 1970..2037, 2 no such date, 3 no such
// time; the first failing check wins and epoch_seconds is zero then.
// Reset empties both registers. While the receiver stalls, the result is
// held; the input register still fills, and in_stall rises once it is full.
// ----------------------------------------------------------------------------
module civil_datetime_to_epoch_seconds (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [cdte_pkg::YEAR_W-1:0]       year,
  input  logic [cdte_pkg::FIELD_W-1:0]      month,
  input  logic [cdte_pkg::FIELD_W-1:0]      day,
  input  logic [cdte_pkg::FIELD_W-1:0]      hour,
  input  logic [cdte_pkg::FIELD_W-1:0]      minute,
  input  logic [cdte_pkg::FIELD_W-1:0]      second,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [cdte_pkg::STATUS_W-1:0]     status,
  output logic [cdte_pkg::EPOCH_W-1:0]      epoch_seconds
);

  logic                             s1_valid;
  logic [cdte_pkg::YEAR_W-1:0]      s1_year;
  logic [cdte_pkg::FIELD_W-1:0]     s1_month;
  logic [cdte_pkg::FIELD_W-1:0]     s1_day;
  logic [cdte_pkg::FIELD_W-1:0]     s1_hour;
  logic [cdte_pkg::FIELD_W-1:0]     s1_minute;
  logic [cdte_pkg::FIELD_W-1:0]     s1_second;

  logic                             advance;
  logic                             in_take;

  logic                             year_ok;
  logic                             month_ok;
  logic                             date_ok;
  logic                             time_ok;
  logic                             leap;
  logic [3:0]                       month_idx;
  logic [4:0]                       mlen;
  logic [cdte_pkg::YOFF_W-1:0]      y_off;
  logic [7:0]                       y_off_inc;
  logic [cdte_pkg::DAYS_W-1:0]      year_days;
  logic [cdte_pkg::DAYS_W-1:0]      leap_days;
  logic [cdte_pkg::DAYS_W-1:0]      day_count;
  logic [31:0]                      day_secs;
  logic [cdte_pkg::TOD_W-1:0]       tod_secs;
  logic [cdte_pkg::EPOCH_W-1:0]     total_secs;
  cdte_pkg::status_t                status_next;
  logic [cdte_pkg::EPOCH_W-1:0]     epoch_next;

  assign advance  = !out_valid || !out_stall;
  assign in_stall = s1_valid && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance || !s1_valid) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_year   <= year;
      s1_month  <= month;
      s1_day    <= day;
      s1_hour   <= hour;
      s1_minute <= minute;
      s1_second <= second;
    end
  end

  // checks
  assign year_ok   = (s1_year >= cdte_pkg::YEAR_MIN) && (s1_year <= cdte_pkg::YEAR_MAX);
  assign leap      = (s1_year[1:0] == 2'b00); // 2000 is the only century in range
  assign month_ok  = (s1_month >= 7'd1) && (s1_month <= 7'd12);
  assign month_idx = month_ok ? s1_month[3:0] : 4'd0;
  assign mlen      = cdte_pkg::month_len(month_idx, leap);
  assign date_ok   = month_ok && (s1_day >= 7'd1) && (s1_day <= {2'b00, mlen});
  assign time_ok   = (s1_hour <= 7'd23) && (s1_minute <= 7'd59) && (s1_second <= 7'd59);

  // day count since the epoch
  assign y_off     = cdte_pkg::YOFF_W'(s1_year - cdte_pkg::YEAR_MIN);
  assign y_off_inc = {1'b0, y_off} + 8'd1;
  assign year_days = cdte_pkg::DAYS_W'({8'd0, y_off} * {6'd0, cdte_pkg::DAYS_PER_YEAR});
  assign leap_days = {9'd0, y_off_inc[7:2]};
  assign day_count = year_days + leap_days
                   + {6'd0, cdte_pkg::days_before_month(month_idx, leap)}
                   + {8'd0, s1_day} - 15'd1;

  assign day_secs  = {17'd0, day_count} * {15'd0, cdte_pkg::SECS_PER_DAY};
  assign tod_secs  = cdte_pkg::TOD_W'({10'd0, s1_hour} * {5'd0, cdte_pkg::SECS_PER_HOUR})
                   + cdte_pkg::TOD_W'({10'd0, s1_minute} * {11'd0, cdte_pkg::SECS_PER_MIN})
                   + {10'd0, s1_second};
  assign total_secs = day_secs[cdte_pkg::EPOCH_W-1:0] + {14'd0, tod_secs};

  always_comb begin
    epoch_next = '0;
    if (!year_ok) begin
      status_next = cdte_pkg::STATUS_BAD_YEAR;
    end else if (!date_ok) begin
      status_next = cdte_pkg::STATUS_BAD_DATE;
    end else if (!time_ok) begin
      status_next = cdte_pkg::STATUS_BAD_TIME;
    end else begin
      status_next = cdte_pkg::STATUS_OK;
      epoch_next  = total_secs;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      status        <= status_next;
      epoch_seconds <= epoch_next;
    end
  end

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid && out_stall))
    else $error("input stalled with a free stage");

  a_stage_moves_to_output: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && advance) |=> out_valid)
    else $error("staged word lost on its way to the output");

  a_reject_has_zero_seconds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != cdte_pkg::STATUS_OK)) |-> (epoch_seconds == '0))
    else $error("rejected word carries nonzero seconds");

  a_ok_in_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == cdte_pkg::STATUS_OK)) |-> (epoch_seconds <= cdte_pkg::EPOCH_LAST))
    else $error("seconds beyond the last valid date");

  a_reset_empties: assert property (@(posedge clk)
    rst |=> (!s1_valid && !out_valid))
    else $error("pipeline not empty after reset");
`endif

endmodule

// ===== verif/civil_datetime_to_epoch_seconds_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// civil_datetime_to_epoch_seconds_tb
// Self-checking bench for the date and time to epoch seconds converter.
// Sends directed and random calendar words with random gaps and output
// stalls. Each accepted word is converted here to an expected status and
// second count. These are queued and compared in order against every word
// that the converter hands out.
// ----------------------------------------------------------------------------
module civil_datetime_to_epoch_seconds_tb;

  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef struct packed {
    cdte_pkg::status_t              status;
    logic [cdte_pkg::EPOCH_W-1:0]   epoch;
  } conversion_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [cdte_pkg::YEAR_W-1:0]    year = '0;
  logic [cdte_pkg::FIELD_W-1:0]   month = '0;
  logic [cdte_pkg::FIELD_W-1:0]   day = '0;
  logic [cdte_pkg::FIELD_W-1:0]   hour = '0;
  logic [cdte_pkg::FIELD_W-1:0]   minute = '0;
  logic [cdte_pkg::FIELD_W-1:0]   second = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [cdte_pkg::STATUS_W-1:0]  status;
  logic [cdte_pkg::EPOCH_W-1:0]   epoch_seconds;

  conversion_t   pending_conversions[$];
  int unsigned   month_days[1:12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
  int unsigned   send_idle_pct = 0;
  int unsigned   recv_idle_pct = 0;
  int unsigned   hold_left = 0;
  int unsigned   cycles = 0;
  int unsigned   mismatches = 0;

  civil_datetime_to_epoch_seconds dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .year          (year),
    .month         (month),
    .day           (day),
    .hour          (hour),
    .minute        (minute),
    .second        (second),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .epoch_seconds (epoch_seconds)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("civil_datetime_to_epoch_seconds regression: fail");
      $finish;
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_idle_pct);
  end

  function automatic bit leap_year(input int unsigned y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic int unsigned days_in_month(input int unsigned y, input int unsigned m);
    if (m < 1 || m > 12) begin
      return 0;
    end
    return month_days[m] + ((m == 2 && leap_year(y)) ? 1 : 0);
  endfunction

  function automatic conversion_t predict_conversion(
    input logic [cdte_pkg::YEAR_W-1:0] y, input logic [cdte_pkg::FIELD_W-1:0] mo,
    input logic [cdte_pkg::FIELD_W-1:0] d, input logic [cdte_pkg::FIELD_W-1:0] hh,
    input logic [cdte_pkg::FIELD_W-1:0] mi, input logic [cdte_pkg::FIELD_W-1:0] ss);
    conversion_t  c;
    int unsigned  day_count;
    int unsigned  total;
    c.status = cdte_pkg::STATUS_OK;
    c.epoch = '0;
    if (y < cdte_pkg::YEAR_MIN || y > cdte_pkg::YEAR_MAX) begin
      c.status = cdte_pkg::STATUS_BAD_YEAR;
    end else if (mo < 1 || mo > 12 || d < 1 || d > days_in_month(y, mo)) begin
      c.status = cdte_pkg::STATUS_BAD_DATE;
    end else if (hh > 23 || mi > 59 || ss > 59) begin
      c.status = cdte_pkg::STATUS_BAD_TIME;
    end else begin
      day_count = 0;
      for (int unsigned yr = cdte_pkg::YEAR_MIN; yr < y; yr++) begin
        day_count += leap_year(yr) ? 366 : 365;
      end
      for (int unsigned m = 1; m < mo; m++) begin
        day_count += days_in_month(y, m);
      end
      day_count += d - 1;
      total = day_count * 86400 + hh * 3600 + mi * 60 + ss;
      c.epoch = total[cdte_pkg::EPOCH_W-1:0];
    end
    return c;
  endfunction

  // result checker
  always @(posedge clk) begin
    conversion_t exp_c;
    if (!rst && out_valid && !out_stall) begin
      if (pending_conversions.size() == 0) begin
        $error("unexpected word: status %0d epoch_seconds %0d", status, epoch_seconds);
        mismatches++;
      end else begin
        exp_c = pending_conversions.pop_front();
        if (status !== exp_c.status) begin
          $error("status: expected %0d, got %0d", exp_c.status, status);
          mismatches++;
        end
        if (epoch_seconds !== exp_c.epoch) begin
          $error("epoch_seconds: expected %0d, got %0d", exp_c.epoch, epoch_seconds);
          mismatches++;
        end
      end
    end
  end

  task automatic send_word(
    input int unsigned y, input int unsigned mo, input int unsigned d,
    input int unsigned hh, input int unsigned mi, input int unsigned ss);
    conversion_t                   exp_c;
    logic [cdte_pkg::YEAR_W-1:0]   y_w;
    logic [cdte_pkg::FIELD_W-1:0]  mo_w;
    logic [cdte_pkg::FIELD_W-1:0]  d_w;
    logic [cdte_pkg::FIELD_W-1:0]  hh_w;
    logic [cdte_pkg::FIELD_W-1:0]  mi_w;
    logic [cdte_pkg::FIELD_W-1:0]  ss_w;
    y_w  = cdte_pkg::YEAR_W'(y);
    mo_w = cdte_pkg::FIELD_W'(mo);
    d_w  = cdte_pkg::FIELD_W'(d);
    hh_w = cdte_pkg::FIELD_W'(hh);
    mi_w = cdte_pkg::FIELD_W'(mi);
    ss_w = cdte_pkg::FIELD_W'(ss);
    exp_c = predict_conversion(y_w, mo_w, d_w, hh_w, mi_w, ss_w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    year     <= y_w;
    month    <= mo_w;
    day      <= d_w;
    hour     <= hh_w;
    minute   <= mi_w;
    second   <= ss_w;
    do @(posedge clk); while (in_stall);
    pending_conversions.push_back(exp_c);
  endtask

  task automatic send_valid_datetime();
    int unsigned y;
    int unsigned m;
    y = $urandom_range(cdte_pkg::YEAR_MAX, cdte_pkg::YEAR_MIN);
    m = $urandom_range(12, 1);
    send_word(y, m, $urandom_range(days_in_month(y, m), 1),
              $urandom_range(23), $urandom_range(59), $urandom_range(59));
  endtask

  task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  task automatic test_field_extremes();
    send_word(1970, 1, 1, 0, 0, 0);
    send_word(2037, 12, 31, 23, 59, 59);
    send_word(1969, 12, 31, 23, 59, 59);
    send_word(2038, 1, 1, 0, 0, 0);
    send_word(0, 1, 1, 0, 0, 0);
    send_word(16383, 127, 127, 127, 127, 127);
    send_word(2000, 0, 10, 12, 0, 0);
    send_word(2000, 13, 10, 12, 0, 0);
    send_word(2000, 127, 10, 12, 0, 0);
    send_word(2000, 5, 0, 12, 0, 0);
    send_word(2000, 5, 32, 12, 0, 0);
    send_word(2000, 5, 127, 12, 0, 0);
    send_word(1999, 6, 15, 24, 0, 0);
    send_word(1999, 6, 15, 0, 60, 0);
    send_word(1999, 6, 15, 0, 0, 60);
    send_word(1999, 6, 15, 127, 127, 127);
  endtask

  task automatic test_leap_years();
    send_word(2000, 2, 29, 6, 30, 15);
    send_word(2001, 2, 29, 6, 30, 15);
    send_word(2004, 2, 29, 6, 30, 15);
    send_word(1970, 2, 28, 0, 0, 0);
    send_word(2036, 12, 31, 23, 59, 59);
    send_word(2010, 4, 30, 1, 2, 3);
    send_word(2010, 4, 31, 1, 2, 3);
  endtask

  task automatic test_check_order();
    send_word(1900, 0, 0, 99, 99, 99);
    send_word(2020, 2, 30, 99, 99, 99);
  endtask

  task automatic test_random_dates(input int unsigned count);
    int unsigned   kind;
    int unsigned   y;
    int unsigned   m;
    int unsigned   hh;
    int unsigned   mi;
    int unsigned   ss;
    for (int unsigned i = 0; i < count; i++) begin
      kind = $urandom_range(99);
      y = $urandom_range(cdte_pkg::YEAR_MAX, cdte_pkg::YEAR_MIN);
      m = $urandom_range(12, 1);
      if (kind < 65) begin
        send_valid_datetime();
      end else if (kind < 76) begin
        hh = $urandom_range(23);
        mi = $urandom_range(59);
        ss = $urandom_range(59);
        case ($urandom_range(2))
          0: hh = $urandom_range(127, 24);
          1: mi = $urandom_range(127, 60);
          default: ss = $urandom_range(127, 60);
        endcase
        send_word(y, m, $urandom_range(days_in_month(y, m), 1), hh, mi, ss);
      end else if (kind < 86) begin
        if ($urandom_range(1)) begin
          send_word(y, $urandom_range(127), $urandom_range(127),
                    $urandom_range(23), $urandom_range(59), $urandom_range(59));
        end else begin
          send_word(y, m, $urandom_range(127, days_in_month(y, m)),
                    $urandom_range(23), $urandom_range(59), $urandom_range(59));
        end
      end else begin
        send_word($urandom_range(16383), $urandom_range(127), $urandom_range(127),
                  $urandom_range(127), $urandom_range(127), $urandom_range(127));
      end
    end
  endtask

  task automatic test_backpressure();
    while (hold_left != 0) @(posedge clk);
    hold_left <= 80;
    set_idling(0, 0);
    for (int unsigned i = 0; i < 30; i++) begin
      send_valid_datetime();
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    set_idling(23, 51);
    test_field_extremes();
    test_leap_years();
    test_check_order();
    test_random_dates(310);
    set_idling(51, 23);
    test_random_dates(310);
    set_idling(0, 0);
    test_random_dates(310);
    test_backpressure();
    in_valid <= 1'b0;
    while (pending_conversions.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("civil_datetime_to_epoch_seconds regression: pass");
    end else begin
      $display("civil_datetime_to_epoch_seconds regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/cdte_pkg.sv
sv/civil_datetime_to_epoch_seconds.sv
verif/civil_datetime_to_epoch_seconds_tb.sv
